@@ design/replica_quorum_tally_defines.svh @@
// Assertion macros used by the checker file rqt_checker.sv.
`ifndef REPLICA_QUORUM_TALLY_DEFINES_SVH
`define REPLICA_QUORUM_TALLY_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define RQT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("replica_quorum_tally: check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define RQT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("replica_quorum_tally: check failed");

`endif

@@ design/rqt_pkg.sv @@
package rqt_pkg;

  localparam int CFG_W   = 6;
  localparam int TGT_W   = 6;
  localparam int OKC_W   = 6;
  localparam int IN_TDW  = 16;
  localparam int OUT_TDW = 16;

  typedef enum logic [2:0] {
    ST_UNKNOWN  = 3'd0,
    ST_OK       = 3'd1,
    ST_NOINFO   = 3'd2,
    ST_OUTDATED = 3'd3,
    ST_UNAVAIL  = 3'd4
  } status_e;

  typedef enum logic {
    OP_MERGE   = 1'b0,
    OP_RESTART = 1'b1
  } op_e;

  typedef struct packed {
    logic clear;
    logic step;
  } tally_ctl_t;

  // codes above unavailable are taken as no_info
  function automatic status_e sanitize_status(logic [2:0] code);
    status_e st;
    case (code)
      3'd0:    st = ST_UNKNOWN;
      3'd1:    st = ST_OK;
      3'd2:    st = ST_NOINFO;
      3'd3:    st = ST_OUTDATED;
      3'd4:    st = ST_UNAVAIL;
      default: st = ST_NOINFO;
    endcase
    return st;
  endfunction

endpackage

@@ design/rqt_slot_store.sv @@
module rqt_slot_store #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clear_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  rqt_pkg::status_e wr_data_i,
  output rqt_pkg::status_e rd_data_o
);
  import rqt_pkg::*;

  logic [2:0]       mem_q [DEPTH];
  logic [DEPTH-1:0] valid_q;
  logic [2:0]       rd_data_q;
  logic             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // per-entry valid bits: an unwritten or cleared slot reads as unknown
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (clear_i) begin
        valid_q <= '0;
      end else if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? sanitize_status(rd_data_q) : ST_UNKNOWN;

endmodule

@@ design/rqt_tally.sv @@
module rqt_tally #(
  parameter int CW = 6,
  parameter int AW = 5
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  rqt_pkg::tally_ctl_t      ctl_i,
  input  rqt_pkg::status_e         cur_i,
  input  logic [AW-1:0]            slot_idx_i,
  input  logic                     reset_old_i,
  input  logic [rqt_pkg::TGT_W-1:0] tgt_i,
  input  rqt_pkg::status_e         reply_i,
  input  logic [CW-1:0]            n_i,
  output rqt_pkg::status_e         new_o,
  output logic                     decided_o,
  output rqt_pkg::status_e         owner_o,
  output logic [CW-1:0]            ok_o
);
  import rqt_pkg::*;

  logic [CW-1:0] unk_q, ok_q, outd_q, unav_q;
  logic [CW-1:0] maj;
  logic [CW:0]   ok_unk;
  status_e       st;

  always_comb begin
    st = cur_i;
    if (reset_old_i && (st != ST_UNKNOWN) && (st != ST_UNAVAIL)) begin
      st = ST_OUTDATED;
    end
    if (7'(slot_idx_i) == 7'(tgt_i)) begin
      st = reply_i;
    end
  end

  assign new_o = st;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unk_q  <= '0;
      ok_q   <= '0;
      outd_q <= '0;
      unav_q <= '0;
    end else if (ctl_i.clear) begin
      unk_q  <= '0;
      ok_q   <= '0;
      outd_q <= '0;
      unav_q <= '0;
    end else if (ctl_i.step) begin
      case (st)
        ST_UNKNOWN:  unk_q  <= unk_q + CW'(1);
        ST_OK:       ok_q   <= ok_q + CW'(1);
        ST_OUTDATED: outd_q <= outd_q + CW'(1);
        ST_UNAVAIL:  unav_q <= unav_q + CW'(1);
        default:     ;
      endcase
    end
  end

  assign maj    = (n_i >> 1) + CW'(1);
  assign ok_unk = {1'b0, ok_q} + {1'b0, unk_q};
  assign ok_o   = ok_q;

  always_comb begin
    decided_o = 1'b0;
    owner_o   = ST_UNKNOWN;
    if (ok_q >= maj) begin
      decided_o = 1'b1;
      owner_o   = ST_OK;
    end else if (ok_unk < {1'b0, maj}) begin
      decided_o = 1'b1;
      if (unav_q > (n_i - maj)) begin
        owner_o = ST_UNAVAIL;
      end else if (outd_q != '0) begin
        owner_o = ST_OUTDATED;
      end else begin
        owner_o = ST_NOINFO;
      end
    end
  end

endmodule

@@ design/replica_quorum_tally.sv @@
// Replica quorum tally.
// Slave stream carries one request: tuser = op (0 merge a reply, 1 restart round),
// tdata = reply_status, target_index, reset_old. Master stream returns one result
// per request: tuser = owner_decided, tdata = owner_status, ok_count.
// cfg_we_i/cfg_wdata_i set replica_count (0 acts as 1, above MAX_REPLICAS clamps);
// write it only while idle.
// A merge sweeps slots 0..n-1 through the slot store (one read and one write port),
// one slot per cycle, rewriting each slot and counting it; the vote is then taken
// on the counters. A merge passes S_SWEEP, S_DECIDE and S_FIN, a restart only
// S_FIN; a new request is taken once the result is in the output register.
// A restart clears all slot valid bits when it is accepted.
// Reset: all slots unknown, replica_count 1, output empty.
// If the receiver stalls, the result holds in the output register; a further
// result waits in the sequencer and s_axis_tready stays low until it moves on.
module replica_quorum_tally #(
  parameter int MAX_REPLICAS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [rqt_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [2:0] reply_status, [8:3] target_index, [9] reset_old, [15:10] zero
  input  logic [rqt_pkg::IN_TDW-1:0]   s_axis_tdata,
  // [0] op
  input  logic                         s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [2:0] owner_status, [8:3] ok_count, [15:9] zero
  output logic [rqt_pkg::OUT_TDW-1:0]  m_axis_tdata,
  // [0] owner_decided
  output logic                         m_axis_tuser
);
  import rqt_pkg::*;

  localparam int AW = (MAX_REPLICAS > 1) ? $clog2(MAX_REPLICAS) : 1;
  localparam int CW = $clog2(MAX_REPLICAS + 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SWEEP  = 4'b0010,
    S_DECIDE = 4'b0100,
    S_FIN    = 4'b1000
  } state_e;

  state_e          state_q, state_d;
  logic [CFG_W-1:0] cnt_cfg_q;
  logic [CW-1:0]   i_q, i_d;
  logic            pv_q, pv_d;
  logic [AW-1:0]   pidx_q, pidx_d;
  status_e         reply_q, reply_d;
  logic [TGT_W-1:0] tgt_q, tgt_d;
  logic            rold_q, rold_d;
  logic            res_dec_q, res_dec_d;
  status_e         res_st_q, res_st_d;
  logic [OKC_W-1:0] res_ok_q, res_ok_d;
  logic            m_valid_q, m_valid_d;
  logic            m_dec_q, m_dec_d;
  status_e         m_st_q, m_st_d;
  logic [OKC_W-1:0] m_ok_q, m_ok_d;

  logic [6:0]      cfg_ext;
  logic [CW-1:0]   n_eff;
  logic            accept, rd_en, store_clear;
  tally_ctl_t      tctl;
  status_e         cur_st, new_st, owner;
  logic            decided;
  logic [CW-1:0]   ok_cnt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_cfg_q <= CFG_W'(1);
    end else if (cfg_we_i) begin
      cnt_cfg_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    cfg_ext = {1'b0, cnt_cfg_q};
    if (cfg_ext == 7'd0) begin
      n_eff = CW'(1);
    end else if (cfg_ext > 7'(MAX_REPLICAS)) begin
      n_eff = CW'(MAX_REPLICAS);
    end else begin
      n_eff = CW'(cfg_ext);
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign store_clear   = accept && (s_axis_tuser == OP_RESTART);

  always_comb begin
    state_d   = state_q;
    i_d       = i_q;
    pv_d      = 1'b0;
    pidx_d    = pidx_q;
    reply_d   = reply_q;
    tgt_d     = tgt_q;
    rold_d    = rold_q;
    res_dec_d = res_dec_q;
    res_st_d  = res_st_q;
    res_ok_d  = res_ok_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    m_dec_d   = m_dec_q;
    m_st_d    = m_st_q;
    m_ok_d    = m_ok_q;
    rd_en     = 1'b0;
    tctl      = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (s_axis_tuser == OP_RESTART) begin
            res_dec_d = 1'b0;
            res_st_d  = ST_UNKNOWN;
            res_ok_d  = '0;
            state_d   = S_FIN;
          end else begin
            reply_d    = sanitize_status(s_axis_tdata[2:0]);
            tgt_d      = s_axis_tdata[8:3];
            rold_d     = s_axis_tdata[9];
            i_d        = '0;
            tctl.clear = 1'b1;
            state_d    = S_SWEEP;
          end
        end
      end
      S_SWEEP: begin
        tctl.step = pv_q;
        if (i_q < n_eff) begin
          rd_en  = 1'b1;
          pv_d   = 1'b1;
          pidx_d = i_q[AW-1:0];
          i_d    = i_q + CW'(1);
        end else if (!pv_q) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        res_dec_d = decided;
        res_st_d  = owner;
        res_ok_d  = OKC_W'(ok_cnt);
        state_d   = S_FIN;
      end
      S_FIN: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_dec_d   = res_dec_q;
          m_st_d    = res_st_q;
          m_ok_d    = res_ok_q;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      i_q       <= '0;
      pv_q      <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      i_q       <= i_d;
      pv_q      <= pv_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q    <= pidx_d;
    reply_q   <= reply_d;
    tgt_q     <= tgt_d;
    rold_q    <= rold_d;
    res_dec_q <= res_dec_d;
    res_st_q  <= res_st_d;
    res_ok_q  <= res_ok_d;
    m_dec_q   <= m_dec_d;
    m_st_q    <= m_st_d;
    m_ok_q    <= m_ok_d;
  end

  rqt_slot_store #(
    .DEPTH (MAX_REPLICAS),
    .AW    (AW)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (store_clear),
    .rd_en_i   (rd_en),
    .rd_addr_i (i_q[AW-1:0]),
    .wr_en_i   (pv_q),
    .wr_addr_i (pidx_q),
    .wr_data_i (new_st),
    .rd_data_o (cur_st)
  );

  rqt_tally #(
    .CW (CW),
    .AW (AW)
  ) u_tally (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (tctl),
    .cur_i       (cur_st),
    .slot_idx_i  (pidx_q),
    .reset_old_i (rold_q),
    .tgt_i       (tgt_q),
    .reply_i     (reply_q),
    .n_i         (n_eff),
    .new_o       (new_st),
    .decided_o   (decided),
    .owner_o     (owner),
    .ok_o        (ok_cnt)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_dec_q;
  assign m_axis_tdata  = {(OUT_TDW - 3 - OKC_W)'(0), m_ok_q, m_st_q};

endmodule

@@ design/rqt_checker.sv @@
`include "replica_quorum_tally_defines.svh"

module rqt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // one request in flight: no back-to-back accept
  `RQT_ASSERT_NEXT(a_busy_after_req, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // undecided results carry status zero
  `RQT_ASSERT_NOW(a_undecided_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[2:0] == 3'd0)

  // a decided owner is ok, no_info, outdated or unavailable
  `RQT_ASSERT_NOW(a_decided_code, m_axis_tvalid && m_axis_tuser,
    m_axis_tdata[2:0] == 3'd1 || m_axis_tdata[2:0] == 3'd2 ||
    m_axis_tdata[2:0] == 3'd3 || m_axis_tdata[2:0] == 3'd4)

  `RQT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind replica_quorum_tally rqt_checker u_rqt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

@@ tb/quorum_vote_checker.sv @@
module quorum_vote_checker #(
  parameter int MaxReplicas = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [rqt_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  logic                        s_tvalid_i,
  input  logic                        s_tready_i,
  input  logic [rqt_pkg::IN_TDW-1:0]  s_tdata_i,
  input  logic                        s_tuser_i,
  input  logic                        m_tvalid_i,
  input  logic                        m_tready_i,
  input  logic [rqt_pkg::OUT_TDW-1:0] m_tdata_i,
  input  logic                        m_tuser_i,
  output int                          mismatches_o,
  output int                          pending_o,
  output int                          checked_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import rqt_pkg::*;

  typedef struct packed {
    logic             decided;
    status_e          owner;
    logic [OKC_W-1:0] ok_cnt;
  } vote_t;

  status_e          slot_q [MaxReplicas];
  logic [CFG_W-1:0] replica_cnt_q;
  vote_t            owner_expected_q [$];
  vote_t            want_v;

  task automatic report_mismatch(string what, int got, int want);
    mismatches_o++;
    $display("[%0t] %s: got %0d, want %0d", $realtime, what, got, want);
  endtask

  function automatic void queue_vote(vote_t v);
    owner_expected_q.insert(owner_expected_q.size(), v);
  endfunction

  // merge one reply into the slot states and take the vote
  function automatic vote_t tally_reply(logic [2:0] code, logic [TGT_W-1:0] tgt, logic ro);
    vote_t   v;
    status_e rs;
    status_e st;
    int      n;
    int      majority;
    int      n_unk;
    int      n_ok;
    int      n_out;
    int      n_unav;
    rs = (code > ST_UNAVAIL) ? ST_NOINFO : status_e'(code);
    n = int'(replica_cnt_q);
    if (n == 0) n = 1;
    if (n > MaxReplicas) n = MaxReplicas;
    majority = n / 2 + 1;
    n_unk = 0;
    n_ok = 0;
    n_out = 0;
    n_unav = 0;
    for (int i = 0; i < n; i++) begin
      st = slot_q[i];
      if (ro && st != ST_UNKNOWN && st != ST_UNAVAIL) st = ST_OUTDATED;
      if (i == int'(tgt)) st = rs;
      slot_q[i] = st;
      case (st)
        ST_UNKNOWN:  n_unk++;
        ST_OK:       n_ok++;
        ST_OUTDATED: n_out++;
        ST_UNAVAIL:  n_unav++;
        default: ;
      endcase
    end
    v.decided = 1'b0;
    v.owner   = ST_UNKNOWN;
    v.ok_cnt  = n_ok[OKC_W-1:0];
    if (n_ok >= majority) begin
      v.decided = 1'b1;
      v.owner   = ST_OK;
    end else if (n_ok + n_unk < majority) begin
      v.decided = 1'b1;
      if (n_unav > n - majority) v.owner = ST_UNAVAIL;
      else if (n_out != 0) v.owner = ST_OUTDATED;
      else v.owner = ST_NOINFO;
    end
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (slot_q[i]) slot_q[i] = ST_UNKNOWN;
      replica_cnt_q = CFG_W'(1);
      owner_expected_q.delete();
      mismatches_o = 0;
      checked_o    = 0;
    end else begin
      if (cfg_we_i) replica_cnt_q = cfg_wdata_i;
      // results first: a result never belongs to a request taken at the same edge
      if (m_tvalid_i && m_tready_i) begin
        if (owner_expected_q.size() == 0) begin
          report_mismatch("result with no request pending", int'(m_tdata_i), 0);
        end else begin
          want_v = owner_expected_q.pop_front();
          checked_o++;
          if (m_tuser_i !== want_v.decided)
            report_mismatch("owner_decided", int'(m_tuser_i), int'(want_v.decided));
          if (m_tdata_i[2:0] !== want_v.owner)
            report_mismatch("owner_status", int'(m_tdata_i[2:0]), int'(want_v.owner));
          if (m_tdata_i[8:3] !== want_v.ok_cnt)
            report_mismatch("ok_count", int'(m_tdata_i[8:3]), int'(want_v.ok_cnt));
          if (m_tdata_i[OUT_TDW-1:9] !== '0)
            report_mismatch("tdata padding", int'(m_tdata_i[OUT_TDW-1:9]), 0);
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        if (s_tuser_i == OP_RESTART) begin
          foreach (slot_q[i]) slot_q[i] = ST_UNKNOWN;
          queue_vote('0);
        end else begin
          queue_vote(tally_reply(s_tdata_i[2:0], s_tdata_i[8:3], s_tdata_i[9]));
        end
      end
    end
    pending_o = owner_expected_q.size();
  end

endmodule

@@ tb/replica_quorum_tally_tb.sv @@
module replica_quorum_tally_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rqt_pkg::*;

  localparam int MaxReplicas = 32;
  localparam int CycleLimit  = 500000;
  localparam int LongHold    = 300;
  localparam int DrainTail   = 40;

  // reserved reply codes, stored as no_info
  localparam logic [2:0] CODE_RSVD_A = 3'd5;
  localparam logic [2:0] CODE_RSVD_B = 3'd6;
  localparam logic [2:0] CODE_RSVD_C = 3'd7;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [CFG_W-1:0]   cfg_wdata = '0;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [IN_TDW-1:0]  s_tdata = '0;
  logic               s_tuser = 1'b0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [OUT_TDW-1:0] m_tdata;
  logic               m_tuser;

  int mismatches;
  int pending;
  int checked;
  int cycles = 0;
  int n_sent = 0;
  int n_restart = 0;
  int n_settings = 0;
  bit gaps_on = 1'b1;
  bit hold_req = 1'b0;
  bit hold_taken = 1'b0;

  replica_quorum_tally #(
    .MAX_REPLICAS(MaxReplicas)
  ) u_top (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_tready),
    .s_axis_tdata (s_tdata),
    .s_axis_tuser (s_tuser),
    .m_axis_tvalid(m_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_tdata),
    .m_axis_tuser (m_tuser)
  );

  quorum_vote_checker #(
    .MaxReplicas(MaxReplicas)
  ) u_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .s_tvalid_i  (s_tvalid),
    .s_tready_i  (s_tready),
    .s_tdata_i   (s_tdata),
    .s_tuser_i   (s_tuser),
    .m_tvalid_i  (m_tvalid),
    .m_tready_i  (m_tready),
    .m_tdata_i   (m_tdata),
    .m_tuser_i   (m_tuser),
    .mismatches_o(mismatches),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  always #4 clk = ~clk;

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // result side backpressure
  initial begin
    int burst;
    @(posedge clk);
    forever begin
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        m_tready <= 1'b0;
        repeat (LongHold) @(posedge clk);
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 12);
        m_tready <= 1'b0;
        repeat (burst) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_req(op_e op, logic [2:0] code, logic [TGT_W-1:0] tgt, logic ro);
    int gap;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {6'b0, ro, tgt, code};
    do @(posedge clk); while (!s_tready);
    n_sent++;
    if (op == OP_RESTART) n_restart++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_cfg(logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    n_settings++;
  endtask

  function automatic logic [2:0] pick_status();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return ST_OK;
    if (r < 45) return ST_UNKNOWN;
    if (r < 60) return ST_NOINFO;
    if (r < 75) return ST_OUTDATED;
    if (r < 95) return ST_UNAVAIL;
    return 3'($urandom_range(CODE_RSVD_A, CODE_RSVD_C));
  endfunction

  // drain, set the replica count, then restart and send rounds of random replies and restarts
  task automatic run_phase(logic [CFG_W-1:0] cnt, int items);
    int n;
    int sent;
    int len;
    int tgt;
    drain();
    write_cfg(cnt);
    n = (cnt == 0) ? 1 : ((cnt > MaxReplicas) ? MaxReplicas : cnt);
    sent = 0;
    while (sent < items) begin
      send_req(OP_RESTART, 3'($urandom), 6'($urandom), 1'($urandom));
      sent++;
      len = $urandom_range(1, n + 4);
      repeat (len) begin
        if ($urandom_range(0, 99) < 8) tgt = $urandom_range(n, 63);
        else tgt = $urandom_range(0, n - 1);
        if ($urandom_range(0, 99) < 3)
          send_req(OP_RESTART, 3'($urandom), 6'($urandom), 1'($urandom));
        else
          send_req(OP_MERGE, pick_status(), 6'(tgt), $urandom_range(0, 9) == 0);
        sent++;
      end
    end
  endtask

  initial begin
    logic [CFG_W-1:0] counts [16];
    counts = '{6'd7, 6'd0, 6'd3, 6'd1, 6'd32, 6'd63, 6'd2, 6'd16,
               6'd33, 6'd5, 6'd31, 6'd4, 6'd12, 6'd9, 6'd20, 6'd6};
    wait (rst_n);
    @(posedge clk);

    // replica count at its reset value of one
    send_req(OP_MERGE, ST_OK, 6'd0, 1'b0);
    send_req(OP_MERGE, ST_UNAVAIL, 6'd0, 1'b0);
    send_req(OP_MERGE, ST_UNKNOWN, 6'd0, 1'b0);
    send_req(OP_MERGE, ST_NOINFO, 6'd0, 1'b0);
    send_req(OP_MERGE, ST_OUTDATED, 6'd0, 1'b0);
    send_req(OP_MERGE, CODE_RSVD_C, 6'd0, 1'b0);
    send_req(OP_MERGE, ST_OK, 6'd63, 1'b1);
    send_req(OP_RESTART, ST_UNKNOWN, 6'd0, 1'b0);
    drain();
    write_cfg(6'd5);
    send_req(OP_MERGE, ST_OK, 6'd0, 1'b0);
    send_req(OP_MERGE, ST_OK, 6'd1, 1'b0);
    send_req(OP_MERGE, ST_NOINFO, 6'd2, 1'b0);
    send_req(OP_MERGE, ST_OK, 6'd4, 1'b0);
    send_req(OP_MERGE, ST_UNAVAIL, 6'd3, 1'b1);
    send_req(OP_MERGE, ST_UNAVAIL, 6'd0, 1'b0);
    send_req(OP_MERGE, ST_UNAVAIL, 6'd1, 1'b0);
    send_req(OP_MERGE, CODE_RSVD_A, 6'd5, 1'b0);
    send_req(OP_MERGE, CODE_RSVD_B, 6'd2, 1'b0);
    send_req(OP_RESTART, ST_UNKNOWN, 6'd0, 1'b0);
    send_req(OP_MERGE, ST_OK, 6'd4, 1'b0);
    send_req(OP_RESTART, CODE_RSVD_C, 6'd63, 1'b1);

    for (int p = 0; p < 16; p++) begin
      if (p == 15) gaps_on = 1'b0;
      if (p == 2) hold_req = 1'b1;
      run_phase(counts[p], 92);
    end

    drain();
    repeat (DrainTail) @(posedge clk);
    $display("Sent %0d requests (%0d restarts) across %0d replica counts, 0 and 63 included.",
             n_sent, n_restart, n_settings);
    $display("Checked %0d results, with random gaps, a long output stall and full drains.",
             checked);
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ replica_quorum_tally.f @@
+incdir+design
design/rqt_pkg.sv
design/rqt_slot_store.sv
design/rqt_tally.sv
design/replica_quorum_tally.sv
design/rqt_checker.sv
tb/quorum_vote_checker.sv
tb/replica_quorum_tally_tb.sv
